>>> hdl/rmtp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmtp_pkg: shared types and constants of the rate-monotonic task picker
// Field widths of the request and response channels and the command codes.
// ----------------------------------------------------------------------------
package rmtp_pkg;

	localparam int CMD_W    = 2;
	localparam int PERIOD_W = 31;
	localparam int TASK_W   = 3;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [PERIOD_W-1:0] period_t;
	typedef logic [TASK_W-1:0]   task_idx_t;

	localparam cmd_t CMD_ADD   = 2'd0;
	localparam cmd_t CMD_START = 2'd1;
	localparam cmd_t CMD_SCHED = 2'd2;

	// All-ones period: "no limit" for the slice, never chosen as a task
	localparam period_t NO_LIMIT = '1;

endpackage
`default_nettype wire

>>> hdl/rmtp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmtp_if: request and response channels of the task picker
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rmtp_req_if;
	logic                 valid;
	logic                 ready;
	rmtp_pkg::cmd_t       cmd;
	rmtp_pkg::period_t    task_period;
	rmtp_pkg::period_t    used_time;
	logic                 task_finished;

	modport source (output valid, output cmd, output task_period, output used_time,
		output task_finished, input ready);
	modport sink (input valid, input cmd, input task_period, input used_time,
		input task_finished, output ready);
endinterface

interface rmtp_rsp_if;
	logic                 valid;
	logic                 ready;
	rmtp_pkg::task_idx_t  next_task;
	logic                 next_valid;
	rmtp_pkg::task_idx_t  prev_task;
	logic                 prev_valid;
	rmtp_pkg::period_t    slice_time;
	logic                 save_context;
	logic                 restart_prev;
	logic                 add_accepted;

	modport source (output valid, output next_task, output next_valid, output prev_task,
		output prev_valid, output slice_time, output save_context, output restart_prev,
		output add_accepted, input ready);
	modport sink (input valid, input next_task, input next_valid, input prev_task,
		input prev_valid, input slice_time, input save_context, input restart_prev,
		input add_accepted, output ready);
endinterface
`default_nettype wire

>>> hdl/rmtp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmtp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rmtp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

>>> hdl/rate_monotonic_task_picker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rate_monotonic_task_picker_core: rate-monotonic periodic task scheduler
// Holds a table of task periods and times-to-run, and on each schedule
// command picks the ready task with the shortest period plus the time slice
// until the release of the shortest-period task that is not ready.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake      payload
//   -------  ---  -------------  ---------------------------------------------
//   req      in   valid / ready  cmd, task_period, used_time, task_finished
//   rsp      out  valid / ready  next_task, next_valid, prev_task, prev_valid,
//                                slice_time, save_context, restart_prev,
//                                add_accepted
//
// Start and schedule walk the period and time-to-run RAMs over the tasks
// added, one entry per cycle; start on an empty table skips the walk, and a
// schedule whose running task finished first adds its period back. The
// schedule walk goes through a single shared add/subtract unit.
// Reset clears the task count and the running task; the tables stay undefined
// until added and armed. req.ready is high only while the sequencer idles; a
// finished result waits in the rsp register while the next request is worked.
// ----------------------------------------------------------------------------
module rate_monotonic_task_picker_core #(
	parameter int MAX_TASKS = 8,
	parameter int TIME_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	rmtp_req_if.sink     req,
	rmtp_rsp_if.source   rsp
);

	localparam int IW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNTW = $clog2(MAX_TASKS + 1);
	localparam int PW   = rmtp_pkg::PERIOD_W;
	localparam int CW   = (TIME_BITS > PW) ? TIME_BITS : PW;

	typedef logic [TIME_BITS-1:0] time_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_ARM   = 6'b000010,
		ST_FWR   = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_SLICE = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	typedef struct packed {
		rmtp_pkg::task_idx_t next_task;
		logic                next_valid;
		rmtp_pkg::task_idx_t prev_task;
		logic                prev_valid;
		rmtp_pkg::period_t   slice_time;
		logic                save_context;
		logic                restart_prev;
		logic                add_accepted;
	} result_t;

	// Bring a period into the time domain (wraps modulo 2^TIME_BITS)
	function automatic time_t to_time(input rmtp_pkg::period_t p);
		logic [CW-1:0] w;
		w = CW'(p);
		return w[TIME_BITS-1:0];
	endfunction

	// Control state
	state_t            state_q;
	logic [CNTW-1:0]   count_q;
	logic [CNTW-1:0]   k_q;
	logic              vld_s1;
	logic [IW-1:0]     running_task_q;
	logic              running_valid_q;
	logic              pick_valid_q;
	logic              out_valid_q;

	// Datapath state
	logic [IW-1:0]     idx_s1;
	time_t             used_q;
	rmtp_pkg::period_t best_per_q;
	rmtp_pkg::period_t lim_per_q;
	time_t             lim_ttr_q;
	logic [IW-1:0]     pick_q;
	result_t           res_q;
	result_t           out_q;

	// RAM ports
	logic [IW-1:0]     rd_addr;
	rmtp_pkg::period_t per_rd;
	time_t             ttr_rd;
	logic              per_we;
	logic              ttr_we;
	logic [IW-1:0]     ttr_wr_addr;
	time_t             ttr_wr_data;

	// Shared add/subtract unit
	time_t             alu_a;
	time_t             alu_b;
	logic              alu_sub;
	time_t             alu_y;

	logic              req_xfer;
	logic              has_room;
	logic              rd_en;
	logic              ttr_ok;
	logic              out_load;
	logic [CW-1:0]     slice_cw;
	rmtp_pkg::period_t slice_val;

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign has_room  = (count_q < CNTW'(MAX_TASKS));
	assign rd_en     = (k_q < count_q);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	// Read the running task's entry while idle so a finish adjust is ready at once;
	// otherwise walk the table with the entry counter.
	assign rd_addr = (state_q == ST_IDLE) ? running_task_q : k_q[IW-1:0];

	// Add: store the period at the next free slot
	assign per_we = req_xfer && (req.cmd == rmtp_pkg::CMD_ADD) && has_room;

	rmtp_ram #(
		.WIDTH (PW),
		.DEPTH (MAX_TASKS)
	) u_period_ram (
		.clk     (clk),
		.wr_en   (per_we),
		.wr_addr (count_q[IW-1:0]),
		.wr_data (req.task_period),
		.rd_addr (rd_addr),
		.rd_data (per_rd)
	);

	rmtp_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (MAX_TASKS)
	) u_ttr_ram (
		.clk     (clk),
		.wr_en   (ttr_we),
		.wr_addr (ttr_wr_addr),
		.wr_data (ttr_wr_data),
		.rd_addr (rd_addr),
		.rd_data (ttr_rd)
	);

	// Operand select: finish adjust adds the period, the walk subtracts the
	// used time, the slice step subtracts the limiting period.
	always_comb begin
		alu_a   = ttr_rd;
		alu_b   = used_q;
		alu_sub = 1'b1;
		case (state_q)
			ST_FWR: begin
				alu_b   = to_time(per_rd);
				alu_sub = 1'b0;
			end
			ST_SLICE: begin
				alu_a = lim_ttr_q;
				alu_b = to_time(lim_per_q);
			end
			default: begin
				alu_sub = 1'b1;
			end
		endcase
	end

	assign alu_y  = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
	assign ttr_ok = (CW'(alu_y) <= CW'(per_rd));

	// Saturate the slice to the all-ones "unlimited" code
	assign slice_cw  = CW'(alu_y);
	assign slice_val = (lim_per_q == rmtp_pkg::NO_LIMIT) ? rmtp_pkg::NO_LIMIT :
		((slice_cw > CW'(rmtp_pkg::NO_LIMIT)) ? rmtp_pkg::NO_LIMIT : slice_cw[PW-1:0]);

	// Time-to-run write back
	always_comb begin
		ttr_we      = 1'b0;
		ttr_wr_addr = idx_s1;
		ttr_wr_data = alu_y;
		case (state_q)
			ST_ARM: begin
				ttr_we      = vld_s1;
				ttr_wr_data = to_time(per_rd);
			end
			ST_FWR: begin
				ttr_we      = 1'b1;
				ttr_wr_addr = running_task_q;
			end
			ST_SCAN: begin
				ttr_we = vld_s1;
			end
			default: begin
				ttr_we = 1'b0;
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			count_q         <= '0;
			k_q             <= '0;
			vld_s1          <= 1'b0;
			running_task_q  <= '0;
			running_valid_q <= 1'b0;
			pick_valid_q    <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			// drop the result once taken, unless a fresh one loads below
			if (rsp.valid && rsp.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						k_q    <= '0;
						vld_s1 <= 1'b0;
						case (req.cmd)
							rmtp_pkg::CMD_ADD: begin
								if (has_room) begin
									count_q <= count_q + CNTW'(1);
								end
								state_q <= ST_DONE;
							end
							rmtp_pkg::CMD_START: begin
								state_q <= (count_q == '0) ? ST_DONE : ST_ARM;
							end
							rmtp_pkg::CMD_SCHED: begin
								pick_valid_q <= 1'b0;
								state_q <= (running_valid_q && req.task_finished) ?
									ST_FWR : ST_SCAN;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_ARM: begin
					vld_s1 <= rd_en;
					if (rd_en) begin
						k_q <= k_q + CNTW'(1);
					end
					if (!rd_en && !vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_FWR: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					vld_s1 <= rd_en;
					if (rd_en) begin
						k_q <= k_q + CNTW'(1);
					end
					if (vld_s1 && ttr_ok && (per_rd < best_per_q)) begin
						pick_valid_q <= 1'b1;
					end
					if (!rd_en && !vld_s1) begin
						state_q <= ST_SLICE;
					end
				end
				ST_SLICE: begin
					running_task_q  <= pick_valid_q ? pick_q : '0;
					running_valid_q <= pick_valid_q;
					state_q         <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= k_q[IW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					used_q     <= to_time(req.used_time);
					best_per_q <= rmtp_pkg::NO_LIMIT;
					lim_per_q  <= rmtp_pkg::NO_LIMIT;
					lim_ttr_q  <= '0;
					pick_q     <= '0;
					res_q      <= '{
						next_task:    '0,
						next_valid:   1'b0,
						prev_task:    ((req.cmd == rmtp_pkg::CMD_SCHED) && running_valid_q) ?
							rmtp_pkg::TASK_W'(running_task_q) : '0,
						prev_valid:   (req.cmd == rmtp_pkg::CMD_SCHED) && running_valid_q,
						slice_time:   '0,
						save_context: (req.cmd == rmtp_pkg::CMD_SCHED) &&
							!(running_valid_q && req.task_finished),
						restart_prev: (req.cmd == rmtp_pkg::CMD_SCHED) && running_valid_q &&
							req.task_finished,
						add_accepted: (req.cmd == rmtp_pkg::CMD_ADD) && has_room
					};
				end
			end
			ST_SCAN: begin
				// keep the shortest ready period; earliest index wins ties
				if (vld_s1) begin
					if (ttr_ok) begin
						if (per_rd < best_per_q) begin
							best_per_q <= per_rd;
							pick_q     <= idx_s1;
						end
					end else if (per_rd < lim_per_q) begin
						lim_per_q <= per_rd;
						lim_ttr_q <= alu_y;
					end
				end
			end
			ST_SLICE: begin
				res_q <= '{
					next_task:    pick_valid_q ? rmtp_pkg::TASK_W'(pick_q) : '0,
					next_valid:   pick_valid_q,
					prev_task:    res_q.prev_task,
					prev_valid:   res_q.prev_valid,
					slice_time:   slice_val,
					save_context: res_q.save_context,
					restart_prev: res_q.restart_prev,
					add_accepted: res_q.add_accepted
				};
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.next_task    = out_q.next_task;
	assign rsp.next_valid   = out_q.next_valid;
	assign rsp.prev_task    = out_q.prev_task;
	assign rsp.prev_valid   = out_q.prev_valid;
	assign rsp.slice_time   = out_q.slice_time;
	assign rsp.save_context = out_q.save_context;
	assign rsp.restart_prev = out_q.restart_prev;
	assign rsp.add_accepted = out_q.add_accepted;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_TASKS))
		else $error("task count beyond table depth");

	a_running_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		running_valid_q |-> (CNTW'(running_task_q) < count_q))
		else $error("running task outside the filled table");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == ST_DONE))
		else $error("result presented outside the done step");

	a_save_restart_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.save_context && rsp.restart_prev))
		else $error("save and restart both flagged");

endmodule
`default_nettype wire
